>>> src/qppt_pkg.sv
// ============================================================================
// qppt_pkg
// Shared types and constants for the quaternion pose point transform.
// ============================================================================
package qppt_pkg;

  // field widths
  localparam int QUAT_FRAC_BITS = 14;
  localparam int POS_WIDTH      = 24;

  // derived arithmetic widths
  localparam int QW       = QUAT_FRAC_BITS + 2;          // quaternion component
  localparam int MAT_FRAC = 2 * QUAT_FRAC_BITS;          // matrix fraction bits
  localparam int PROD_W   = 2 * QW;                      // quaternion product
  localparam int MAT_W    = PROD_W + 2;                  // matrix entry
  localparam int VEC_W    = POS_WIDTH + 1;               // cam + offset
  localparam int TERM_W   = MAT_W + VEC_W;               // matrix * vector term
  localparam int ACC_W    = TERM_W + 2;                  // row sum of three terms
  localparam int RND_W    = ACC_W - MAT_FRAC;            // rounded row
  localparam int SUM_W    = RND_W + 1;                   // rounded row + position

  localparam int NUM_STAGES = 5;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [QW-1:0]        quat_elem_t;
  typedef logic signed [POS_WIDTH-1:0] pos_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [MAT_W-1:0]     mat_elem_t;
  typedef logic signed [VEC_W-1:0]     vec_elem_t;
  typedef logic signed [TERM_W-1:0]    term_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [RND_W-1:0]     rnd_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  // matrix one and rounding half
  localparam mat_elem_t MAT_ONE    = mat_elem_t'(1) <<< MAT_FRAC;
  localparam acc_t      ROUND_HALF = acc_t'(1) <<< (MAT_FRAC - 1);

  // output range limits
  localparam pos_t POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  // hand-eye offset reset values, micrometres
  localparam pos_t HEO_X_RESET = pos_t'(-40141);
  localparam pos_t HEO_Y_RESET = pos_t'(-116625);
  localparam pos_t HEO_Z_RESET = pos_t'(70759);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEO_X = 2'd0,
    CFG_HEO_Y = 2'd1,
    CFG_HEO_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    quat_elem_t x;
    quat_elem_t y;
    quat_elem_t z;
    quat_elem_t w;
  } quat_t;

  typedef struct packed {
    quat_elem_t quat_x;
    quat_elem_t quat_y;
    quat_elem_t quat_z;
    quat_elem_t quat_w;
    pos_t       end_pos_x;
    pos_t       end_pos_y;
    pos_t       end_pos_z;
    pos_t       cam_x;
    pos_t       cam_y;
    pos_t       cam_z;
  } in_req_t;

  typedef struct packed {
    pos_t base_x;
    pos_t base_y;
    pos_t base_z;
    logic saturated;
  } out_res_t;

  // load enables of a two-stage unit
  typedef struct packed {
    logic first;
    logic second;
  } stage_ld_t;

endpackage

>>> src/qppt_rot_gen.sv
// ============================================================================
// qppt_rot_gen
// Rotation matrix builder: quaternion products, then the nine matrix entries.
// ============================================================================
module qppt_rot_gen (
  input  logic                 clk,
  input  qppt_pkg::stage_ld_t  ld,
  input  qppt_pkg::quat_t      quat,
  output qppt_pkg::mat_elem_t  mat [9]
);

  qppt_pkg::prod_t xx, yy, zz, xy, xz, yz, xw, yw, zw;

  // product doubled and widened to a matrix entry
  function automatic qppt_pkg::mat_elem_t twice(input qppt_pkg::prod_t p);
    qppt_pkg::mat_elem_t e;
    e = qppt_pkg::mat_elem_t'(p);
    return e <<< 1;
  endfunction

  // stage 1: pairwise quaternion products
  always_ff @(posedge clk) begin
    if (ld.first) begin
      xx <= quat.x * quat.x;
      yy <= quat.y * quat.y;
      zz <= quat.z * quat.z;
      xy <= quat.x * quat.y;
      xz <= quat.x * quat.z;
      yz <= quat.y * quat.z;
      xw <= quat.x * quat.w;
      yw <= quat.y * quat.w;
      zw <= quat.z * quat.w;
    end
  end

  // stage 2: unnormalised rotation matrix, row major
  always_ff @(posedge clk) begin
    if (ld.second) begin
      mat[0] <= qppt_pkg::MAT_ONE - twice(yy) - twice(zz);
      mat[1] <= twice(xy) - twice(zw);
      mat[2] <= twice(xz) + twice(yw);
      mat[3] <= twice(xy) + twice(zw);
      mat[4] <= qppt_pkg::MAT_ONE - twice(xx) - twice(zz);
      mat[5] <= twice(yz) - twice(xw);
      mat[6] <= twice(xz) - twice(yw);
      mat[7] <= twice(yz) + twice(xw);
      mat[8] <= qppt_pkg::MAT_ONE - twice(xx) - twice(yy);
    end
  end

endmodule

>>> src/qppt_mat_vec.sv
// ============================================================================
// qppt_mat_vec
// Matrix times vector: nine registered products, then row sums with rounding.
// ============================================================================
module qppt_mat_vec (
  input  logic                 clk,
  input  qppt_pkg::stage_ld_t  ld,
  input  qppt_pkg::mat_elem_t  mat [9],
  input  qppt_pkg::vec_elem_t  vec [3],
  output qppt_pkg::rnd_t       rnd [3]
);

  qppt_pkg::term_t term [9];
  qppt_pkg::acc_t  acc  [3];

  // stage 3: one product per matrix entry
  always_ff @(posedge clk) begin
    if (ld.first) begin
      for (int i = 0; i < 9; i++) begin
        term[i] <= mat[i] * vec[i % 3];
      end
    end
  end

  // row sums plus half an lsb
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = qppt_pkg::acc_t'(term[3*r]) + qppt_pkg::acc_t'(term[3*r+1])
             + qppt_pkg::acc_t'(term[3*r+2]) + qppt_pkg::ROUND_HALF;
    end
  end

  // stage 4: floor to whole micrometres
  always_ff @(posedge clk) begin
    if (ld.second) begin
      for (int r = 0; r < 3; r++) begin
        rnd[r] <= acc[r][qppt_pkg::ACC_W-1:qppt_pkg::MAT_FRAC];
      end
    end
  end

endmodule

>>> src/quaternion_pose_point_transform_core.sv
// ============================================================================
// quaternion_pose_point_transform_core
// Maps a camera-frame point to the robot base frame through a quaternion pose.
// ============================================================================
//
// Usage:
//   in_valid/in_ready/in_data carry one request: the pose quaternion (Q2.14),
//   the end-effector position and the camera-frame point, all in micrometres.
//   out_valid/out_ready/out_data return base = R(q)*(cam + offset) + end_pos,
//   saturated to the signed position range, with a flag when any axis clips.
//   cfg_we/cfg_index/cfg_data write the three hand-eye offsets; write them
//   only while no request is in flight.
// Timing:
//   five register stages (quaternion products, matrix, matrix-vector
//   products, row sum and rounding, position add and clip).
//   One request per cycle sustained while out_ready stays high; every
//   stage holds one request.
// Reset:
//   empties the pipeline and loads the default hand-eye offsets.
// Stall:
//   when out_ready is low the stages fill up behind the output register,
//   bubbles close up, and in_ready drops once all five stages hold data.
//
module quaternion_pose_point_transform_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qppt_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qppt_pkg::out_res_t                  out_data,
  input  logic                                cfg_we,
  input  logic [qppt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qppt_pkg::POS_WIDTH-1:0]      cfg_data
);

  localparam int N = qppt_pkg::NUM_STAGES;

  qppt_pkg::pos_t      heo_x, heo_y, heo_z;
  logic [N-1:0]        vld;
  logic [N-1:0]        ld;
  qppt_pkg::quat_t     quat;
  qppt_pkg::stage_ld_t rot_ld, mv_ld;
  qppt_pkg::mat_elem_t mat [9];
  qppt_pkg::rnd_t      rnd [3];
  qppt_pkg::vec_elem_t vec1 [3];
  qppt_pkg::vec_elem_t vec2 [3];
  qppt_pkg::pos_t      epos1 [3];
  qppt_pkg::pos_t      epos2 [3];
  qppt_pkg::pos_t      epos3 [3];
  qppt_pkg::pos_t      epos4 [3];
  qppt_pkg::sum_t      sum  [3];
  qppt_pkg::pos_t      clip [3];
  logic [2:0]          clipped;
  qppt_pkg::out_res_t  out_res;

  // hand-eye offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heo_x <= qppt_pkg::HEO_X_RESET;
      heo_y <= qppt_pkg::HEO_Y_RESET;
      heo_z <= qppt_pkg::HEO_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qppt_pkg::CFG_HEO_X: heo_x <= cfg_data;
        qppt_pkg::CFG_HEO_Y: heo_y <= cfg_data;
        qppt_pkg::CFG_HEO_Z: heo_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage load enables: a stage takes new data when empty or draining
  always_comb begin
    ld[4] = !vld[4] || out_ready;
    ld[3] = !vld[3] || ld[4];
    ld[2] = !vld[2] || ld[3];
    ld[1] = !vld[1] || ld[2];
    ld[0] = !vld[0] || ld[1];
  end

  assign in_ready = ld[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (ld[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // rotation matrix unit, stages 1 and 2
  assign quat = '{x: in_data.quat_x, y: in_data.quat_y,
                  z: in_data.quat_z, w: in_data.quat_w};
  assign rot_ld = '{first: ld[0], second: ld[1]};

  qppt_rot_gen u_rot_gen (
    .clk  (clk),
    .ld   (rot_ld),
    .quat (quat),
    .mat  (mat)
  );

  // stage 1 and 2: offset point and end position alongside the matrix
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      vec1[0]  <= qppt_pkg::vec_elem_t'(in_data.cam_x) + qppt_pkg::vec_elem_t'(heo_x);
      vec1[1]  <= qppt_pkg::vec_elem_t'(in_data.cam_y) + qppt_pkg::vec_elem_t'(heo_y);
      vec1[2]  <= qppt_pkg::vec_elem_t'(in_data.cam_z) + qppt_pkg::vec_elem_t'(heo_z);
      epos1[0] <= in_data.end_pos_x;
      epos1[1] <= in_data.end_pos_y;
      epos1[2] <= in_data.end_pos_z;
    end
    if (ld[1]) begin
      vec2  <= vec1;
      epos2 <= epos1;
    end
  end

  // matrix-vector unit, stages 3 and 4
  assign mv_ld = '{first: ld[2], second: ld[3]};

  qppt_mat_vec u_mat_vec (
    .clk (clk),
    .ld  (mv_ld),
    .mat (mat),
    .vec (vec2),
    .rnd (rnd)
  );

  // end position delay for stages 3 and 4
  always_ff @(posedge clk) begin
    if (ld[2]) epos3 <= epos2;
    if (ld[3]) epos4 <= epos3;
  end

  // add end position and clip to the position range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = qppt_pkg::sum_t'(rnd[i]) + qppt_pkg::sum_t'(epos4[i]);
      if (sum[i][qppt_pkg::SUM_W-1:qppt_pkg::POS_WIDTH-1] == '0 ||
          sum[i][qppt_pkg::SUM_W-1:qppt_pkg::POS_WIDTH-1] == '1) begin
        clip[i]    = sum[i][qppt_pkg::POS_WIDTH-1:0];
        clipped[i] = 1'b0;
      end else begin
        clip[i]    = sum[i][qppt_pkg::SUM_W-1] ? qppt_pkg::POS_MIN : qppt_pkg::POS_MAX;
        clipped[i] = 1'b1;
      end
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      out_res <= '{base_x: clip[0], base_y: clip[1], base_z: clip[2],
                   saturated: |clipped};
    end
  end

  assign out_valid = vld[N-1];
  assign out_data  = out_res;

`ifndef SYNTHESIS
  // requests in flight change only by accepted inputs and outputs
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) == $past($countones(vld))
                + int'($past(in_valid && in_ready))
                - int'($past(out_valid && out_ready))))
    else $error("pipeline occupancy mismatch");

  // a saturated result has at least one axis at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      (out_data.base_x == qppt_pkg::POS_MAX || out_data.base_x == qppt_pkg::POS_MIN ||
       out_data.base_y == qppt_pkg::POS_MAX || out_data.base_y == qppt_pkg::POS_MIN ||
       out_data.base_z == qppt_pkg::POS_MAX || out_data.base_z == qppt_pkg::POS_MIN))
    else $error("saturated flag without a clipped axis");

  // a full pipeline with a stalled receiver takes no new request
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (vld == '1 && !out_ready) |-> !in_ready)
    else $error("request taken while pipeline full and stalled");
`endif

endmodule

>>> verif/tb_quaternion_pose_point_transform_core.sv
// ============================================================================
// tb_quaternion_pose_point_transform_core
// Self-checking bench for the quaternion pose point transform. Requests carry
// a pose and a camera-frame point; a scoreboard class predicts each base-frame
// point and checks results in order while both sides idle and stall at random.
// ============================================================================
`timescale 1ns / 100ps

module tb_quaternion_pose_point_transform_core;

  localparam int CLK_HALF  = 5;
  localparam int LONG_HOLD = 60;

  // handy quaternion and position values
  localparam int Q_ONE  = 1 << qppt_pkg::QUAT_FRAC_BITS;
  localparam int Q_HALF = Q_ONE / 2;
  localparam int Q_DIAG = 11585;                 // cos(45 deg) in Q2.14
  localparam int Q_MAX  = (1 << (qppt_pkg::QW - 1)) - 1;
  localparam int Q_MIN  = -(1 << (qppt_pkg::QW - 1));
  localparam int P_MAX  = int'(qppt_pkg::POS_MAX);
  localparam int P_MIN  = int'(qppt_pkg::POS_MIN);

  // index with no register behind it
  localparam logic [qppt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = '1;

  // --------------------------------------------------------------------------
  // scoreboard: predicts base-frame points and checks them in order
  // --------------------------------------------------------------------------
  class pose_scoreboard;
    qppt_pkg::pos_t     off_x;
    qppt_pkg::pos_t     off_y;
    qppt_pkg::pos_t     off_z;
    qppt_pkg::out_res_t expected_points[$];
    int                 errors;

    function new();
      off_x  = qppt_pkg::HEO_X_RESET;
      off_y  = qppt_pkg::HEO_Y_RESET;
      off_z  = qppt_pkg::HEO_Z_RESET;
      errors = 0;
    endfunction

    function void set_offset(logic [qppt_pkg::CFG_IDX_W-1:0] idx, qppt_pkg::pos_t val);
      case (idx)
        qppt_pkg::CFG_HEO_X: off_x = val;
        qppt_pkg::CFG_HEO_Y: off_y = val;
        qppt_pkg::CFG_HEO_Z: off_z = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // R(q) * (cam + offset) + end_pos, rounded half up, clipped
    function qppt_pkg::out_res_t transform_point(qppt_pkg::in_req_t r);
      longint             qx, qy, qz, qw, one, acc, sum;
      longint             rot[9];
      longint             pt[3];
      longint             org[3];
      qppt_pkg::pos_t     coords[3];
      qppt_pkg::out_res_t o;
      qx = r.quat_x;
      qy = r.quat_y;
      qz = r.quat_z;
      qw = r.quat_w;
      pt[0] = longint'(r.cam_x) + longint'(off_x);
      pt[1] = longint'(r.cam_y) + longint'(off_y);
      pt[2] = longint'(r.cam_z) + longint'(off_z);
      org[0] = r.end_pos_x;
      org[1] = r.end_pos_y;
      org[2] = r.end_pos_z;
      one = longint'(1) <<< qppt_pkg::MAT_FRAC;
      // unnormalised rotation matrix, 2*QUAT_FRAC_BITS fraction bits
      rot[0] = one - 2 * qy * qy - 2 * qz * qz;
      rot[1] = 2 * qx * qy - 2 * qz * qw;
      rot[2] = 2 * qx * qz + 2 * qy * qw;
      rot[3] = 2 * qx * qy + 2 * qz * qw;
      rot[4] = one - 2 * qx * qx - 2 * qz * qz;
      rot[5] = 2 * qy * qz - 2 * qx * qw;
      rot[6] = 2 * qx * qz - 2 * qy * qw;
      rot[7] = 2 * qy * qz + 2 * qx * qw;
      rot[8] = one - 2 * qx * qx - 2 * qy * qy;
      o.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = rot[3*i] * pt[0] + rot[3*i+1] * pt[1] + rot[3*i+2] * pt[2];
        sum = ((acc + (longint'(1) <<< (qppt_pkg::MAT_FRAC - 1)))
               >>> qppt_pkg::MAT_FRAC) + org[i];
        if (sum > qppt_pkg::POS_MAX) begin
          sum = qppt_pkg::POS_MAX;
          o.saturated = 1'b1;
        end else if (sum < qppt_pkg::POS_MIN) begin
          sum = qppt_pkg::POS_MIN;
          o.saturated = 1'b1;
        end
        coords[i] = qppt_pkg::pos_t'(sum);
      end
      o.base_x = coords[0];
      o.base_y = coords[1];
      o.base_z = coords[2];
      return o;
    endfunction

    function void note_request(qppt_pkg::in_req_t r);
      expected_points.push_back(transform_point(r));
    endfunction

    function void compare_field(string name, qppt_pkg::pos_t want, qppt_pkg::pos_t got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(qppt_pkg::out_res_t got);
      qppt_pkg::out_res_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: result with no request pending, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      compare_field("base_x", want.base_x, got.base_x);
      compare_field("base_y", want.base_y, got.base_y);
      compare_field("base_z", want.base_z, got.base_z);
      compare_field("saturated", qppt_pkg::pos_t'(want.saturated),
                    qppt_pkg::pos_t'(got.saturated));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  qppt_pkg::in_req_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  qppt_pkg::out_res_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [qppt_pkg::CFG_IDX_W-1:0] cfg_index = qppt_pkg::CFG_HEO_X;
  logic [qppt_pkg::POS_WIDTH-1:0] cfg_data  = '0;

  bit             hold_req = 1'b0;
  pose_scoreboard sb       = new();

  always #CLK_HALF clk = ~clk;

  quaternion_pose_point_transform_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------
  function automatic qppt_pkg::in_req_t point_request(int qx, int qy, int qz, int qw,
                                                      int ex, int ey, int ez,
                                                      int cx, int cy, int cz);
    qppt_pkg::in_req_t r;
    r.quat_x    = qppt_pkg::quat_elem_t'(qx);
    r.quat_y    = qppt_pkg::quat_elem_t'(qy);
    r.quat_z    = qppt_pkg::quat_elem_t'(qz);
    r.quat_w    = qppt_pkg::quat_elem_t'(qw);
    r.end_pos_x = qppt_pkg::pos_t'(ex);
    r.end_pos_y = qppt_pkg::pos_t'(ey);
    r.end_pos_z = qppt_pkg::pos_t'(ez);
    r.cam_x     = qppt_pkg::pos_t'(cx);
    r.cam_y     = qppt_pkg::pos_t'(cy);
    r.cam_z     = qppt_pkg::pos_t'(cz);
    return r;
  endfunction

  // signed value spread over span bits
  function automatic qppt_pkg::pos_t rand_pos(int span);
    return qppt_pkg::pos_t'(int'($urandom & ((1 << span) - 1)) - (1 << (span - 1)));
  endfunction

  function automatic qppt_pkg::quat_t random_unit_quat();
    real             a[4];
    real             n;
    qppt_pkg::quat_t q;
    for (int k = 0; k < 4; k++) a[k] = $urandom_range(0, 2000000) / 1000000.0 - 1.0;
    n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
    if (n < 0.001) begin
      q   = '0;
      q.w = qppt_pkg::quat_elem_t'(Q_ONE);
      return q;
    end
    q.x = qppt_pkg::quat_elem_t'($rtoi(a[0] / n * Q_ONE));
    q.y = qppt_pkg::quat_elem_t'($rtoi(a[1] / n * Q_ONE));
    q.z = qppt_pkg::quat_elem_t'($rtoi(a[2] / n * Q_ONE));
    q.w = qppt_pkg::quat_elem_t'($rtoi(a[3] / n * Q_ONE));
    return q;
  endfunction

  // mostly unit poses with moderate points, some raw bits and extremes
  function automatic qppt_pkg::in_req_t random_request();
    qppt_pkg::in_req_t r;
    qppt_pkg::quat_t   q;
    int                kind;
    int                span;
    kind = $urandom_range(0, 9);
    if (kind >= 6 && kind <= 8) q = qppt_pkg::quat_t'({$urandom, $urandom});
    else q = random_unit_quat();
    if (kind == 6 || kind == 7 || kind == 9) span = qppt_pkg::POS_WIDTH;
    else span = $urandom_range(8, 21);
    r.quat_x    = q.x;
    r.quat_y    = q.y;
    r.quat_z    = q.z;
    r.quat_w    = q.w;
    r.end_pos_x = rand_pos(span);
    r.end_pos_y = rand_pos(span);
    r.end_pos_z = rand_pos(span);
    r.cam_x     = rand_pos(span);
    r.cam_y     = rand_pos(span);
    r.cam_z     = rand_pos(span);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_request(qppt_pkg::in_req_t req, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic send_random(int count, int gap_max);
    repeat (count) send_request(random_request(), $urandom_range(0, gap_max));
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(logic [qppt_pkg::CFG_IDX_W-1:0] idx, qppt_pkg::pos_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_offset(idx, val);
  endtask

  // all three offsets plus a write to the empty index
  task automatic load_offsets(qppt_pkg::pos_t ox, qppt_pkg::pos_t oy, qppt_pkg::pos_t oz);
    cfg_write(qppt_pkg::CFG_HEO_X, ox);
    cfg_write(qppt_pkg::CFG_HEO_Y, oy);
    cfg_write(qppt_pkg::CFG_HEO_Z, oz);
    cfg_write(CFG_UNUSED, qppt_pkg::pos_t'($urandom));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int stall_max;
    int taken;
    stall_max = 4;
    taken     = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 32 == 0) stall_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      stall = hold_req ? LONG_HOLD : $urandom_range(0, stall_max);
      hold_req = 1'b0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset offsets: zero point, axis turns, rounding ties, extremes
    send_request(point_request(0, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0), $urandom_range(0, 4));
    send_request(point_request(0, 0, 0, Q_ONE, 1000, -2000, 3000, 0, 0, 0),
                 $urandom_range(0, 4));
    send_request(point_request(0, 0, 0, 0, 0, 0, 0, 12345, -678, 9), $urandom_range(0, 4));
    send_request(point_request(Q_DIAG, 0, 0, Q_DIAG, 1, 2, 3, 100000, 200000, 300000),
                 $urandom_range(0, 4));
    send_request(point_request(0, Q_DIAG, 0, Q_DIAG, -1, -2, -3, 100000, 200000, 300000),
                 $urandom_range(0, 4));
    send_request(point_request(0, 0, Q_DIAG, Q_DIAG, 7, 8, 9, -100000, 50000, -25000),
                 $urandom_range(0, 4));
    send_request(point_request(0, 0, Q_ONE, 0, 0, 0, 0, 4321, -8765, 1111),
                 $urandom_range(0, 4));
    send_request(point_request(0, Q_HALF, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 4));
    send_request(point_request(0, Q_HALF, 0, 0, 0, 0, 0, 40142, 116626, -70758),
                 $urandom_range(0, 4));
    send_request(point_request(Q_ONE, Q_ONE, 0, Q_ONE, 500, 600, 700, 1000, 2000, 3000),
                 $urandom_range(0, 4));
    send_request(point_request(Q_MAX, Q_MAX, Q_MAX, Q_MAX, P_MAX, P_MAX, P_MAX,
                               P_MAX, P_MAX, P_MAX), $urandom_range(0, 4));
    send_request(point_request(Q_MIN, Q_MIN, Q_MIN, Q_MIN, P_MIN, P_MIN, P_MIN,
                               P_MIN, P_MIN, P_MIN), $urandom_range(0, 4));
    send_request(point_request(Q_MIN, Q_MAX, Q_MIN, Q_MAX, P_MIN, P_MAX, 0,
                               P_MAX, P_MIN, P_MAX), $urandom_range(0, 4));
    send_request(point_request(0, 0, 0, Q_ONE, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX),
                 $urandom_range(0, 4));
    send_request(point_request(0, 0, 0, Q_ONE, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN),
                 $urandom_range(0, 4));
    send_request(point_request(0, 0, 0, Q_ONE, P_MAX, 0, P_MIN, 0, 0, 0),
                 $urandom_range(0, 4));
    drain();

    // largest offsets
    load_offsets(qppt_pkg::POS_MAX, qppt_pkg::POS_MAX, qppt_pkg::POS_MAX);
    send_request(point_request(0, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0), $urandom_range(0, 4));
    send_request(point_request(Q_MIN, 0, 0, Q_MAX, 0, 0, 0, P_MAX, P_MAX, P_MAX),
                 $urandom_range(0, 4));
    drain();

    // most negative offsets
    load_offsets(qppt_pkg::POS_MIN, qppt_pkg::POS_MIN, qppt_pkg::POS_MIN);
    send_request(point_request(0, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0), $urandom_range(0, 4));
    send_request(point_request(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, P_MIN, P_MIN, P_MIN),
                 $urandom_range(0, 4));
    drain();

    // random traffic, zero offsets
    load_offsets('0, '0, '0);
    send_random(130, 4);

    // receiver holds off while requests keep coming, pipeline fills up
    hold_req = 1'b1;
    send_random(30, 0);
    drain();

    // random offsets, back-to-back requests
    load_offsets(qppt_pkg::pos_t'($urandom), qppt_pkg::pos_t'($urandom),
                 qppt_pkg::pos_t'($urandom));
    send_random(130, 0);
    drain();

    // moderate random offsets, idling sender
    load_offsets(rand_pos(19), rand_pos(19), rand_pos(19));
    send_random(130, 4);
    drain();

    // let any stray result show up
    repeat (4 * qppt_pkg::NUM_STAGES) @(posedge clk);
    if (sb.errors == 0) $display("PASS quaternion_pose_point_transform_core");
    else $display("FAIL quaternion_pose_point_transform_core");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("FAIL quaternion_pose_point_transform_core");
    $finish;
  end

endmodule

>>> files.f
src/qppt_pkg.sv
src/qppt_rot_gen.sv
src/qppt_mat_vec.sv
src/quaternion_pose_point_transform_core.sv
verif/tb_quaternion_pose_point_transform_core.sv
